FILE: sv/nps_pkg.sv
// nps_pkg: shared types and codes for the nearest point search block.
// No dependencies; imported by every other module of the block.

package nps_pkg;

    localparam int IDX_PORT_W  = 4;
    localparam int DIST_PORT_W = 34;

    localparam logic [1:0] OPC_ADD   = 2'd0;
    localparam logic [1:0] OPC_QUERY = 2'd1;
    localparam logic [1:0] OPC_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        K_ADD,
        K_QUERY,
        K_CLEAR,
        K_NOP
    } t_op_kind;

    typedef struct packed {
        logic     valid;
        t_op_kind kind;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } t_state;

endpackage

FILE: sv/nps_front.sv
// nps_front: accepts items, decodes the op code and holds them in a
// two-entry queue for the back end. Depends on nps_pkg.

module nps_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic [1:0]                i_op,
    input  logic [3*COORD_BITS-1:0]   i_data,
    output nps_pkg::t_cmd             o_cmd,
    output logic [3*COORD_BITS-1:0]   o_cmd_data,
    input  logic                      i_pop
);
    import nps_pkg::*;

    localparam int DEPTH = 2;

    t_op_kind                  r_q_kind [DEPTH];
    logic [3*COORD_BITS-1:0]   r_q_data [DEPTH];
    logic                      r_wr_ptr;
    logic                      r_rd_ptr;
    logic [1:0]                r_q_cnt;
    t_op_kind                  in_kind;
    logic                      push;
    logic                      pop;

    always_comb begin
        case (i_op)
            OPC_ADD:   in_kind = K_ADD;
            OPC_QUERY: in_kind = K_QUERY;
            OPC_CLEAR: in_kind = K_CLEAR;
            default:   in_kind = K_NOP;
        endcase
    end

    assign o_busy = (r_q_cnt == 2'(DEPTH));
    assign push   = i_start && !o_busy;
    assign pop    = i_pop && (r_q_cnt != 2'd0);

    assign o_cmd.valid = (r_q_cnt != 2'd0);
    assign o_cmd.kind  = r_q_kind[r_rd_ptr];
    assign o_cmd_data  = r_q_data[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_kind[r_wr_ptr] <= in_kind;
            r_q_data[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_q_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_q_cnt <= r_q_cnt + 2'd1;
                2'b01:   r_q_cnt <= r_q_cnt - 2'd1;
                default: r_q_cnt <= r_q_cnt;
            endcase
        end
    end

endmodule

FILE: sv/nps_back.sv
// nps_back: point table, add/clear handling and the pipelined linear scan
// for queries. Depends on nps_pkg; fed by nps_front.

module nps_back #(
    parameter int MAX_NODES  = 16,
    parameter int COORD_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  nps_pkg::t_cmd                        i_cmd,
    input  logic [3*COORD_BITS-1:0]              i_cmd_data,
    output logic                                 o_pop,
    output logic                                 o_result_valid,
    output logic [nps_pkg::IDX_PORT_W-1:0]       o_nearest_index,
    output logic [nps_pkg::DIST_PORT_W-1:0]      o_nearest_dist_sq,
    output logic [1:0]                           o_status
);
    import nps_pkg::*;

    localparam int IDX_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int CW     = COORD_BITS;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int DIST_W = 2 * COORD_BITS + 2;

    logic [3*CW-1:0]         r_mem [MAX_NODES];

    t_state                  r_state;
    t_state                  n_state;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        cnt_m1;
    logic                    table_full;
    logic                    pop;
    logic                    issue;
    logic                    issue_last;
    logic [IDX_W-1:0]        r_rd_idx;
    logic [3*CW-1:0]         r_query;

    logic                    r_p1_v, r_p2_v, r_p3_v, r_p4_v;
    logic                    r_p1_last, r_p2_last, r_p3_last, r_p4_last;
    logic [IDX_W-1:0]        r_p1_idx, r_p2_idx, r_p3_idx, r_p4_idx;
    logic [3*CW-1:0]         r_rd_data;
    logic [CW-1:0]           r_abs_x, r_abs_y, r_abs_z;
    logic [SQ_W-1:0]         r_sq_x, r_sq_y, r_sq_z;
    logic [DIST_W-1:0]       r_sum;
    logic [DIST_W-1:0]       r_best_dist;
    logic [IDX_W-1:0]        r_best_idx;

    logic signed [CW:0]      diff_x, diff_y, diff_z;
    logic                    better;
    logic [DIST_W-1:0]       best_dist;
    logic [IDX_W-1:0]        best_idx;

    logic                    r_out_valid;
    logic [IDX_PORT_W-1:0]   r_out_idx;
    logic [DIST_PORT_W-1:0]  r_out_dist;
    logic [1:0]              r_out_status;

    function automatic logic signed [CW:0] axis_diff(input logic [CW-1:0] a,
                                                     input logic [CW-1:0] b);
        return $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    endfunction

    function automatic logic [CW-1:0] axis_abs(input logic signed [CW:0] d);
        logic [CW:0] m;
        m = d[CW] ? -d : d;
        return m[CW-1:0];
    endfunction

    assign table_full = (r_count >= CNT_W'(MAX_NODES));
    assign cnt_m1     = r_count - CNT_W'(1);
    assign issue_last = (r_rd_idx == cnt_m1[IDX_W-1:0]);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid && i_cmd.kind == K_QUERY && r_count != '0) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (issue_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_p4_v && r_p4_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        pop   = 1'b0;
        issue = 1'b0;
        case (r_state)
            S_IDLE:  pop   = i_cmd.valid;
            S_SCAN:  issue = 1'b1;
            default: begin
                pop   = 1'b0;
                issue = 1'b0;
            end
        endcase
    end

    assign o_pop = pop;

    always_ff @(posedge i_clk) begin
        if (pop && i_cmd.kind == K_ADD && !table_full) begin
            r_mem[r_count[IDX_W-1:0]] <= i_cmd_data;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    // scan datapath: read, difference, square, sum
    assign diff_x = axis_diff(r_rd_data[CW-1:0],      r_query[CW-1:0]);
    assign diff_y = axis_diff(r_rd_data[2*CW-1:CW],   r_query[2*CW-1:CW]);
    assign diff_z = axis_diff(r_rd_data[3*CW-1:2*CW], r_query[3*CW-1:2*CW]);

    always_ff @(posedge i_clk) begin
        r_p1_idx  <= r_rd_idx;
        r_p1_last <= issue_last;
        r_p2_idx  <= r_p1_idx;
        r_p2_last <= r_p1_last;
        r_abs_x   <= axis_abs(diff_x);
        r_abs_y   <= axis_abs(diff_y);
        r_abs_z   <= axis_abs(diff_z);
        r_p3_idx  <= r_p2_idx;
        r_p3_last <= r_p2_last;
        r_sq_x    <= SQ_W'(r_abs_x) * SQ_W'(r_abs_x);
        r_sq_y    <= SQ_W'(r_abs_y) * SQ_W'(r_abs_y);
        r_sq_z    <= SQ_W'(r_abs_z) * SQ_W'(r_abs_z);
        r_p4_idx  <= r_p3_idx;
        r_p4_last <= r_p3_last;
        r_sum     <= DIST_W'(r_sq_x) + DIST_W'(r_sq_y) + DIST_W'(r_sq_z);
    end

    // first index wins on a tie
    assign better    = (r_p4_idx == '0) || (r_sum < r_best_dist);
    assign best_dist = better ? r_sum : r_best_dist;
    assign best_idx  = better ? r_p4_idx : r_best_idx;

    always_ff @(posedge i_clk) begin
        if (r_p4_v) begin
            r_best_dist <= best_dist;
            r_best_idx  <= best_idx;
        end
        if (pop) begin
            r_query <= i_cmd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_rd_idx     <= '0;
            r_p1_v       <= 1'b0;
            r_p2_v       <= 1'b0;
            r_p3_v       <= 1'b0;
            r_p4_v       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_idx    <= '0;
            r_out_dist   <= '0;
            r_out_status <= ST_OK;
        end else begin
            r_state     <= n_state;
            r_p1_v      <= issue;
            r_p2_v      <= r_p1_v;
            r_p3_v      <= r_p2_v;
            r_p4_v      <= r_p3_v;
            r_out_valid <= 1'b0;
            if (issue) begin
                r_rd_idx <= r_rd_idx + IDX_W'(1);
            end
            if (pop) begin
                r_rd_idx     <= '0;
                r_out_idx    <= '0;
                r_out_dist   <= '0;
                r_out_status <= ST_OK;
                case (i_cmd.kind)
                    K_ADD: begin
                        r_out_valid <= 1'b1;
                        if (table_full) begin
                            r_out_status <= ST_FULL;
                        end else begin
                            r_out_idx <= IDX_PORT_W'(r_count[IDX_W-1:0]);
                            r_count   <= r_count + CNT_W'(1);
                        end
                    end
                    K_QUERY: begin
                        if (r_count == '0) begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= ST_EMPTY;
                        end
                    end
                    K_CLEAR: begin
                        r_out_valid <= 1'b1;
                        r_count     <= '0;
                    end
                    default: r_out_valid <= 1'b1;
                endcase
            end
            if (r_p4_v && r_p4_last) begin
                r_out_valid  <= 1'b1;
                r_out_idx    <= IDX_PORT_W'(best_idx);
                r_out_dist   <= DIST_PORT_W'(best_dist);
                r_out_status <= ST_OK;
            end
        end
    end

    assign o_result_valid    = r_out_valid;
    assign o_nearest_index   = r_out_idx;
    assign o_nearest_dist_sq = r_out_dist;
    assign o_status          = r_out_status;

endmodule

FILE: sv/nearest_point_search_top.sv
// nearest_point_search_top: add, clear and nearest point query over a table
// of MAX_NODES points. Add, clear, no-op and empty query pass through the queue register
// and then the result register. A query reads one point per cycle, then runs a three-stage
// difference/square/sum pipeline and the result register; results cannot be held off.
// Back end takes one add/clear/no-op per cycle while no query scan runs; a two-entry queue
// takes items meanwhile, busy when full. Sync active-low reset clears counts, state, outputs.

module nearest_point_search_top #(
    parameter int MAX_NODES  = 16,
    parameter int COORD_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           i_op,
    input  logic [COORD_BITS-1:0]                i_x_coord,
    input  logic [COORD_BITS-1:0]                i_y_coord,
    input  logic [COORD_BITS-1:0]                i_z_coord,
    output logic                                 o_result_valid,
    output logic [nps_pkg::IDX_PORT_W-1:0]       o_nearest_index,
    output logic [nps_pkg::DIST_PORT_W-1:0]      o_nearest_dist_sq,
    output logic [1:0]                           o_status
);
    import nps_pkg::*;

    t_cmd                      cmd;
    logic [3*COORD_BITS-1:0]   cmd_data;
    logic                      pop;

    nps_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_op       (i_op),
        .i_data     ({i_z_coord, i_y_coord, i_x_coord}),
        .o_cmd      (cmd),
        .o_cmd_data (cmd_data),
        .i_pop      (pop)
    );

    nps_back #(
        .MAX_NODES  (MAX_NODES),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cmd_data        (cmd_data),
        .o_pop             (pop),
        .o_result_valid    (o_result_valid),
        .o_nearest_index   (o_nearest_index),
        .o_nearest_dist_sq (o_nearest_dist_sq),
        .o_status          (o_status)
    );

endmodule
